FILE: hdl/klso_pkg.sv
// Package for the keyed list with stack operations.
// Holds operation and status codes, field widths and the per-cell command struct.
// No dependencies.
package klso_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = ((OP_W + KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + VAL_W + COUNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;
    localparam logic [OP_W-1:0] OP_POP    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic commit;        // apply the operation this cycle
        logic find_key;      // select cells whose key matches
        logic find_last;     // select the last occupied cell
        logic write_tail;    // the first free cell takes the new entry
        logic shift_on_hit;  // cells at or after the first hit take their neighbor
    } cell_cmd_t;

endpackage

FILE: hdl/klso_cell.sv
// One entry of the keyed list: key and value registers plus compare and shift logic.
// Depends on klso_pkg.
module klso_cell
    import klso_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                           aclk,
    input  cell_cmd_t                      cmd,
    input  logic [$clog2(DEPTH+1)-1:0]     count,
    input  logic [KEY_W-1:0]               new_key,
    input  logic [VAL_W-1:0]               new_val,
    input  logic [KEY_W-1:0]               nbr_key,
    input  logic [VAL_W-1:0]               nbr_val,
    input  logic                           chain_hit_in,
    input  logic [VAL_W-1:0]               chain_val_in,
    output logic                           chain_hit_out,
    output logic [VAL_W-1:0]               chain_val_out,
    output logic [KEY_W-1:0]               own_key,
    output logic [VAL_W-1:0]               own_val
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX    = CW'(INDEX);
    localparam logic [CW-1:0] IDX_P1 = CW'(INDEX + 1);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             occupied;
    logic             sel;

    assign occupied = count > IDX;
    assign sel = (cmd.find_key && occupied && (key_reg == new_key))
              || (cmd.find_last && (count == IDX_P1));

    // The first selected cell in the row wins; later cells pass its value on.
    assign chain_hit_out = chain_hit_in | sel;
    assign chain_val_out = chain_hit_in ? chain_val_in : val_reg;

    always_comb begin
        key_next = key_reg;
        val_next = val_reg;
        if (cmd.commit) begin
            if (cmd.write_tail && (count == IDX)) begin
                key_next = new_key;
                val_next = new_val;
            end else if (cmd.shift_on_hit && (chain_hit_in || sel)) begin
                key_next = nbr_key;
                val_next = nbr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign own_key = key_reg;
    assign own_val = val_reg;

endmodule

FILE: hdl/keyed_list_with_stack_ops.sv
// Top level of the keyed list with stack operations: controller, row of cells, output register.
// Depends on klso_pkg and klso_cell.
//
//  Channel   | Direction | Beat contents (lowest bits first)
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | operation[2:0], key[34:3], value[66:35], zero pad
//  m_axis    | out       | status[1:0], result_value[33:2], entry_count[38:34], pad
//
// Each operation is first accepted into the command registers in the IDLE
// state; then, in the EXEC state, the row of cells compares keys, locates the
// first hit or the last entry through the neighbor chain, shifts and commits.
// The result then sits in the output register; while it waits to be taken
// the next beat can still be accepted, and its execute cycle holds until the
// output register is free. Reset clears the entry count and the control
// state only; the cells' key and value registers are never cleared, because
// only cells below the entry count are ever read.
module keyed_list_with_stack_ops
    import klso_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // operation, key, value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // status, result_value, entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             in_fire;
    logic             exec_fire;
    logic             full;
    cell_cmd_t        cmd;
    logic [KEY_W-1:0] cell_key;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0] result_val;
    logic [31:0]      count_wide;

    logic             hit   [DEPTH+1];
    logic [VAL_W-1:0] cval  [DEPTH+1];
    logic [KEY_W-1:0] own_k [DEPTH+1];
    logic [VAL_W-1:0] own_v [DEPTH+1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign full      = (count_reg == FULL_COUNT);

    // A push stores the entry count it sees as its key.
    assign cell_key = (op_reg == OP_PUSH) ? KEY_W'(count_reg) : key_reg;

    always_comb begin
        cmd = '0;
        cmd.commit = exec_fire;
        case (op_reg)
            OP_ADD, OP_PUSH: cmd.write_tail = !full;
            OP_LOOKUP:       cmd.find_key = 1'b1;
            OP_REMOVE: begin
                cmd.find_key     = 1'b1;
                cmd.shift_on_hit = 1'b1;
            end
            OP_PEEK, OP_POP: cmd.find_last = 1'b1;
            default:         cmd = '0;
        endcase
        if (!exec_fire) begin
            cmd.write_tail   = 1'b0;
            cmd.shift_on_hit = 1'b0;
        end
    end

    // The chain starts with no hit; the cell past the end feeds zeros.
    assign hit[0]       = 1'b0;
    assign cval[0]      = '0;
    assign own_k[DEPTH] = '0;
    assign own_v[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        klso_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .aclk          (aclk),
            .cmd           (cmd),
            .count         (count_reg),
            .new_key       (cell_key),
            .new_val       (val_reg),
            .nbr_key       (own_k[i+1]),
            .nbr_val       (own_v[i+1]),
            .chain_hit_in  (hit[i]),
            .chain_val_in  (cval[i]),
            .chain_hit_out (hit[i+1]),
            .chain_val_out (cval[i+1]),
            .own_key       (own_k[i]),
            .own_val       (own_v[i])
        );
    end

    // Status, returned value and the new entry count for the executing beat.
    always_comb begin
        status     = ST_MISS;
        result_val = '0;
        count_next = count_reg;
        case (op_reg)
            OP_ADD, OP_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    status     = ST_OK;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_LOOKUP, OP_PEEK: begin
                if (hit[DEPTH]) begin
                    status     = ST_OK;
                    result_val = cval[DEPTH];
                end
            end
            OP_REMOVE, OP_POP: begin
                if (hit[DEPTH]) begin
                    status     = ST_OK;
                    result_val = cval[DEPTH];
                    count_next = count_reg - 1'b1;
                end
            end
            default: status = ST_MISS;
        endcase
    end

    assign count_wide = 32'(count_next);

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({count_wide[COUNT_W-1:0], result_val, status});
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_fire) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (in_fire) begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= s_tdata[OP_W+KEY_W-1:OP_W];
            val_reg <= s_tdata[OP_W+KEY_W+VAL_W-1:OP_W+KEY_W];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
